/* rtl/apds_pkg.sv */
// Shared types and constants for the active/pause duty sequencer.
// Used by apds_cfg, apds_step and the top level; depends on nothing.
package apds_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned MinTickMsDefault = 10;
  localparam int unsigned TimeBitsDefault  = 32;

  // Reset values of the configuration registers
  localparam logic [31:0] ACTIVE_BUDGET_RESET = 32'd300000;
  localparam logic [31:0] PAUSE_BUDGET_RESET  = 32'd300000;
  localparam logic [7:0]  TASK_ID_NONE        = 8'hFF;

  // Configuration register indexes
  localparam logic [1:0] CFG_ACTIVE_BUDGET = 2'd0;
  localparam logic [1:0] CFG_PAUSE_BUDGET  = 2'd1;
  localparam logic [1:0] CFG_TASK_ID       = 2'd2;

  typedef enum logic [1:0] {
    PH_INIT   = 2'd0,
    PH_READY  = 2'd1,
    PH_ACTIVE = 2'd2,
    PH_PAUSE  = 2'd3
  } phase_t;

  // Current configuration register contents
  typedef struct packed {
    logic [31:0] active_budget_ms;
    logic [31:0] pause_budget_ms;
    logic [7:0]  task_id;
  } cfg_regs_t;

  // One result item
  typedef struct packed {
    logic [31:0] pause_left_ms;
    logic [31:0] active_left_ms;
    logic [6:0]  announce_id;
    logic        announce;
    phase_t      phase;
  } res_t;

endpackage

/* rtl/active_pause_duty_sequencer.sv */
// Top level of the active/pause duty sequencer: input register, step logic,
// result register. Depends on apds_pkg, apds_cfg and apds_step.
//
// Channel   Direction  Handshake              Payload
// in_       slave      in_tvalid/in_tready    in_tdata[39:0]
// out_      master     out_tvalid/out_tready  out_tdata[79:0]
// cfg_      slave      cfg_valid/cfg_ready    cfg_index[1:0], cfg_data[31:0]
//
// One poll per cycle sustained while out_tready stays high; a poll's result
// reaches out_tdata through the input register, which takes the poll when it is
// accepted, and then the result register, into which the sequencer steps it.
// The state registers update in the same cycle as the result register, so
// back-to-back polls see each other's effect in order.
// Reset (rst_n low, synchronous) empties both registers and puts the sequencer
// in init with default budgets. A stall on out_tready holds the result
// register and backs up to in_tready; cfg_ready is always high.
module active_pause_duty_sequencer
  import apds_pkg::*;
#(
  parameter int unsigned MIN_TICK_MS = MinTickMsDefault,
  parameter int unsigned TIME_BITS   = TimeBitsDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  // now_ms[31:0], go_write[32], go_value[33], zero pad [39:34]
  input  logic [39:0] in_tdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  // phase[1:0], announce[2], announce_id[9:3], active_left_ms[41:10],
  // pause_left_ms[73:42], zero pad [79:74]
  output logic [79:0] out_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  cfg_regs_t cfg_regs;

  logic        in_valid_r;
  logic [33:0] in_data_r;
  logic        out_valid_r;
  res_t        out_r;

  phase_t               phase_r;
  logic                 entry_pending_r;
  logic [TIME_BITS-1:0] time_mark_r;
  logic [31:0]          active_left_r;
  logic [31:0]          pause_left_r;
  logic                 go_flag_r;

  phase_t               phase_nxt;
  logic                 entry_pending_nxt;
  logic [TIME_BITS-1:0] time_mark_nxt;
  logic [31:0]          active_left_nxt;
  logic [31:0]          pause_left_nxt;
  logic                 go_flag_nxt;
  res_t                 res_nxt;

  logic out_adv;
  logic step_fire;

  assign cfg_ready = 1'b1;

  apds_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .regs     (cfg_regs)
  );

  // Pipeline flow control
  assign out_adv   = !out_valid_r || out_tready;
  assign step_fire = in_valid_r && out_adv;
  assign in_tready = !in_valid_r || out_adv;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_data_r <= in_tdata[33:0];
    end
  end

  apds_step #(
    .MIN_TICK_MS (MIN_TICK_MS),
    .TIME_BITS   (TIME_BITS)
  ) u_step (
    .cfg               (cfg_regs),
    .now_ms            (in_data_r[31:0]),
    .go_write          (in_data_r[32]),
    .go_value          (in_data_r[33]),
    .phase             (phase_r),
    .entry_pending     (entry_pending_r),
    .time_mark         (time_mark_r),
    .active_left       (active_left_r),
    .pause_left        (pause_left_r),
    .go_flag           (go_flag_r),
    .phase_nxt         (phase_nxt),
    .entry_pending_nxt (entry_pending_nxt),
    .time_mark_nxt     (time_mark_nxt),
    .active_left_nxt   (active_left_nxt),
    .pause_left_nxt    (pause_left_nxt),
    .go_flag_nxt       (go_flag_nxt),
    .res               (res_nxt)
  );

  // Sequencer state: advance once per stepped poll
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_INIT;
      entry_pending_r <= 1'b1;
      time_mark_r     <= '0;
      active_left_r   <= '0;
      pause_left_r    <= '0;
      go_flag_r       <= 1'b0;
    end else if (step_fire) begin
      phase_r         <= phase_nxt;
      entry_pending_r <= entry_pending_nxt;
      time_mark_r     <= time_mark_nxt;
      active_left_r   <= active_left_nxt;
      pause_left_r    <= pause_left_nxt;
      go_flag_r       <= go_flag_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step_fire) begin
      out_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_r.pause_left_ms, out_r.active_left_ms,
                       out_r.announce_id, out_r.announce, out_r.phase};

`ifndef SYNTHESIS
  // An announced result always reports the ready phase
  a_announce_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.announce) |-> (out_r.phase == PH_READY))
    else $error("announce outside ready phase");

  // A valid task id leaves init on the very next poll
  a_init_leaves: assert property (@(posedge clk) disable iff (!rst_n)
    (step_fire && (phase_r == PH_INIT) && (cfg_regs.task_id != TASK_ID_NONE))
    |=> (phase_r == PH_READY))
    else $error("init did not move to ready with a valid task id");

  // Pause is only reached with the active budget spent
  a_pause_spent: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_PAUSE) |-> (active_left_r == 32'd0))
    else $error("pause phase with active budget left");
`endif

endmodule

/* rtl/apds_cfg.sv */
// Configuration register file of the duty sequencer.
// Depends on apds_pkg for register indexes and reset values.
module apds_cfg
  import apds_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        wr_en,
  input  logic [1:0]  wr_index,
  input  logic [31:0] wr_data,
  output cfg_regs_t   regs
);

  cfg_regs_t regs_r;

  // Write the addressed register; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.active_budget_ms <= ACTIVE_BUDGET_RESET;
      regs_r.pause_budget_ms  <= PAUSE_BUDGET_RESET;
      regs_r.task_id          <= TASK_ID_NONE;
    end else if (wr_en) begin
      case (wr_index)
        CFG_ACTIVE_BUDGET: regs_r.active_budget_ms <= wr_data;
        CFG_PAUSE_BUDGET:  regs_r.pause_budget_ms  <= wr_data;
        CFG_TASK_ID:       regs_r.task_id          <= wr_data[7:0];
        default: begin
        end
      endcase
    end
  end

  assign regs = regs_r;

endmodule

/* rtl/apds_step.sv */
// Next-state logic of the duty sequencer for one poll.
// Depends on apds_pkg for phase codes and the result layout.
module apds_step
  import apds_pkg::*;
#(
  parameter int unsigned MIN_TICK_MS = MinTickMsDefault,
  parameter int unsigned TIME_BITS   = TimeBitsDefault
) (
  input  cfg_regs_t              cfg,
  input  logic [31:0]            now_ms,
  input  logic                   go_write,
  input  logic                   go_value,
  input  phase_t                 phase,
  input  logic                   entry_pending,
  input  logic [TIME_BITS-1:0]   time_mark,
  input  logic [31:0]            active_left,
  input  logic [31:0]            pause_left,
  input  logic                   go_flag,
  output phase_t                 phase_nxt,
  output logic                   entry_pending_nxt,
  output logic [TIME_BITS-1:0]   time_mark_nxt,
  output logic [31:0]            active_left_nxt,
  output logic [31:0]            pause_left_nxt,
  output logic                   go_flag_nxt,
  output res_t                   res
);

  // Width that holds both a budget and an elapsed time
  localparam int unsigned CW = (TIME_BITS > 32) ? TIME_BITS : 32;

  logic [CW-1:0]        now_wide;
  logic [TIME_BITS-1:0] now_t;
  logic [TIME_BITS-1:0] mark_eff;
  logic [TIME_BITS-1:0] elapsed;
  logic                 tick_ok;
  logic                 go_eff;
  logic [31:0]          act_drained;
  logic [31:0]          pau_drained;
  logic                 announce;

  // Subtract elapsed time from a budget, saturating at zero
  function automatic logic [31:0] drain(input logic [31:0] left,
                                        input logic [TIME_BITS-1:0] used);
    logic [CW-1:0] lw;
    logic [CW-1:0] uw;
    lw = CW'(left);
    uw = CW'(used);
    if (lw > uw) begin
      return 32'(lw - uw);
    end
    return 32'd0;
  endfunction

  // Tick reduced to the time width; elapsed wraps naturally
  assign now_wide    = CW'(now_ms);
  assign now_t       = TIME_BITS'(now_wide);
  assign mark_eff    = entry_pending ? now_t : time_mark;
  assign elapsed     = now_t - mark_eff;
  assign tick_ok     = (elapsed >= TIME_BITS'(MIN_TICK_MS));
  assign go_eff      = go_write ? go_value : go_flag;
  assign act_drained = drain(active_left, elapsed);
  assign pau_drained = drain(pause_left, elapsed);

  // Phase transitions and entry actions
  always_comb begin
    phase_nxt         = phase;
    entry_pending_nxt = entry_pending;
    time_mark_nxt     = time_mark;
    active_left_nxt   = active_left;
    pause_left_nxt    = pause_left;
    go_flag_nxt       = go_eff;
    announce          = 1'b0;
    case (phase)
      PH_INIT: begin
        if (entry_pending && (cfg.task_id != TASK_ID_NONE)) begin
          active_left_nxt   = cfg.active_budget_ms;
          phase_nxt         = PH_READY;
          entry_pending_nxt = 1'b1;
        end
      end
      PH_READY: begin
        entry_pending_nxt = 1'b0;
        if (entry_pending) begin
          active_left_nxt = cfg.active_budget_ms;
          pause_left_nxt  = cfg.pause_budget_ms;
          announce        = 1'b1;
          go_flag_nxt     = 1'b0;
        end else if (go_eff) begin
          phase_nxt         = PH_ACTIVE;
          entry_pending_nxt = 1'b1;
        end
      end
      PH_ACTIVE: begin
        entry_pending_nxt = 1'b0;
        time_mark_nxt     = mark_eff;
        if (tick_ok) begin
          active_left_nxt = act_drained;
          time_mark_nxt   = now_t;
          if (act_drained == 32'd0) begin
            phase_nxt         = PH_PAUSE;
            entry_pending_nxt = 1'b1;
          end else if (!go_eff) begin
            phase_nxt         = PH_READY;
            entry_pending_nxt = 1'b1;
          end
        end
      end
      PH_PAUSE: begin
        entry_pending_nxt = 1'b0;
        time_mark_nxt     = mark_eff;
        if (tick_ok) begin
          pause_left_nxt = pau_drained;
          time_mark_nxt  = now_t;
          if (pau_drained == 32'd0) begin
            phase_nxt         = PH_READY;
            entry_pending_nxt = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Assemble the result item
  always_comb begin
    res.phase          = phase_nxt;
    res.announce       = announce;
    res.announce_id    = announce ? cfg.task_id[6:0] : 7'd0;
    res.active_left_ms = active_left_nxt;
    res.pause_left_ms  = pause_left_nxt;
  end

endmodule

/* test/active_pause_duty_sequencer_tb.sv */
`timescale 1ns / 100ps
// Self-checking bench for active_pause_duty_sequencer: stream polls in, compares every result.
// Depends on apds_pkg and the RTL top; carries its own poll-by-poll model of the sequencer.
module active_pause_duty_sequencer_tb;
  import apds_pkg::*;

  localparam int          CYCLE_LIMIT     = 200000;
  localparam int          RANDOM_PHASES   = 10;
  localparam int          POLLS_PER_PHASE = 125;
  localparam logic [31:0] TICK_MS         = MinTickMsDefault;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  // now_ms[31:0], go_write[32], go_value[33], zero pad [39:34]
  logic [39:0] in_tdata   = '0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  // phase[1:0], announce[2], announce_id[9:3], active_left_ms[41:10],
  // pause_left_ms[73:42], zero pad [79:74]
  logic [79:0] out_tdata;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index  = CFG_ACTIVE_BUDGET;
  logic [31:0] cfg_data   = '0;

  // Stimulus and scoreboard
  logic [39:0] pending_polls[$];
  res_t        predicted_results[$];
  logic        in_accepted = 1'b0;
  bit          idle_on = 1'b1;
  int          in_gap = 0;
  int          out_gap = 0;
  int          cycle_count = 0;
  int          mismatch_count = 0;
  logic [31:0] tick_ms = '0;

  // Model state and its copy of the configuration
  phase_t      seq_phase;
  logic        entry_due;
  logic [31:0] mark_ms;
  logic [31:0] active_rem;
  logic [31:0] pause_rem;
  logic        go_bit;
  logic [31:0] cfg_active_ms;
  logic [31:0] cfg_pause_ms;
  logic [7:0]  cfg_task_id;

  active_pause_duty_sequencer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic flag_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 100) $display("mismatch @%0d: %s", cycle_count, msg);
  endtask

  // Subtract elapsed time from a budget, saturating at zero
  function automatic logic [31:0] drain_budget(input logic [31:0] left, input logic [31:0] used);
    return (left > used) ? left - used : '0;
  endfunction

  // Advance the model by one poll and return the result it produces
  function automatic res_t sequencer_step(input logic [31:0] now, input logic go_wr,
                                          input logic go_val);
    res_t        r;
    logic [31:0] elapsed;
    logic        ann;
    ann = 1'b0;
    if (go_wr) go_bit = go_val;
    case (seq_phase)
      PH_INIT: begin
        // init keeps its entry armed; a valid id leaves for ready
        if (entry_due && cfg_task_id != TASK_ID_NONE) begin
          active_rem = cfg_active_ms;
          seq_phase  = PH_READY;
        end
      end
      PH_READY: begin
        if (entry_due) begin
          entry_due  = 1'b0;
          active_rem = cfg_active_ms;
          pause_rem  = cfg_pause_ms;
          ann        = 1'b1;
          go_bit     = 1'b0;
        end
        if (go_bit) begin
          seq_phase = PH_ACTIVE;
          entry_due = 1'b1;
        end
      end
      PH_ACTIVE: begin
        if (entry_due) begin
          entry_due = 1'b0;
          mark_ms   = now;
        end
        elapsed = now - mark_ms;
        if (elapsed >= TICK_MS) begin
          active_rem = drain_budget(active_rem, elapsed);
          mark_ms    = now;
          if (!go_bit) begin
            seq_phase = PH_READY;
            entry_due = 1'b1;
          end
          // spent budget overrides a dropped go
          if (active_rem == '0) begin
            seq_phase = PH_PAUSE;
            entry_due = 1'b1;
          end
        end
      end
      default: begin
        if (entry_due) begin
          entry_due = 1'b0;
          mark_ms   = now;
        end
        elapsed = now - mark_ms;
        if (elapsed >= TICK_MS) begin
          pause_rem = drain_budget(pause_rem, elapsed);
          mark_ms   = now;
          if (pause_rem == '0) begin
            seq_phase = PH_READY;
            entry_due = 1'b1;
          end
        end
      end
    endcase
    r.phase          = seq_phase;
    r.announce       = ann;
    r.announce_id    = ann ? cfg_task_id[6:0] : '0;
    r.active_left_ms = active_rem;
    r.pause_left_ms  = pause_rem;
    return r;
  endfunction

  // Driver: present polls and result backpressure on the falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid  <= 1'b0;
      out_tready <= 1'b0;
    end else begin
      if (in_tvalid && !in_accepted) begin
        // hold the current transaction
      end else if (in_gap > 0) begin
        in_gap--;
        in_tvalid <= 1'b0;
      end else if (idle_on && pending_polls.size() != 0 && $urandom_range(0, 7) == 0) begin
        in_gap = $urandom_range(1, 6) - 1;
        in_tvalid <= 1'b0;
      end else if (pending_polls.size() != 0) begin
        in_tdata  <= pending_polls.pop_front();
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end

      if (out_gap > 0) begin
        out_gap--;
        out_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        out_gap = $urandom_range(1, 6) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Monitor: track config, predict accepted polls, check results
  always @(posedge clk) begin
    res_t got;
    res_t want;
    cycle_count++;
    in_accepted <= in_tvalid && in_tready;
    if (!rst_n) begin
      seq_phase     = PH_INIT;
      entry_due     = 1'b1;
      mark_ms       = '0;
      active_rem    = '0;
      pause_rem     = '0;
      go_bit        = 1'b0;
      cfg_active_ms = ACTIVE_BUDGET_RESET;
      cfg_pause_ms  = PAUSE_BUDGET_RESET;
      cfg_task_id   = TASK_ID_NONE;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ACTIVE_BUDGET: cfg_active_ms = cfg_data;
          CFG_PAUSE_BUDGET:  cfg_pause_ms  = cfg_data;
          CFG_TASK_ID:       cfg_task_id   = cfg_data[7:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        got = res_t'(out_tdata[73:0]);
        if (predicted_results.size() == 0) begin
          flag_mismatch($sformatf("result with nothing outstanding: %h", out_tdata));
        end else begin
          want = predicted_results.pop_front();
          if (got.phase !== want.phase)
            flag_mismatch($sformatf("phase %0d, want %0d", got.phase, want.phase));
          if (got.announce !== want.announce)
            flag_mismatch($sformatf("announce %b, want %b", got.announce, want.announce));
          if (got.announce_id !== want.announce_id)
            flag_mismatch($sformatf("announce_id %0d, want %0d", got.announce_id,
                                    want.announce_id));
          if (got.active_left_ms !== want.active_left_ms)
            flag_mismatch($sformatf("active_left_ms %0d, want %0d", got.active_left_ms,
                                    want.active_left_ms));
          if (got.pause_left_ms !== want.pause_left_ms)
            flag_mismatch($sformatf("pause_left_ms %0d, want %0d", got.pause_left_ms,
                                    want.pause_left_ms));
          if (out_tdata[79:74] !== '0)
            flag_mismatch($sformatf("pad bits %b", out_tdata[79:74]));
        end
      end
      if (in_tvalid && in_tready)
        predicted_results.push_back(sequencer_step(in_tdata[31:0], in_tdata[32], in_tdata[33]));
    end
  end

  // Watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("active_pause_duty_sequencer regression: fail");
    $finish;
  end

  // Queue one poll, moving the tick forward first
  task automatic poll(input logic [31:0] advance, input logic go_wr, input logic go_val);
    tick_ms += advance;
    pending_polls.push_back({6'b0, go_val, go_wr, tick_ms});
  endtask

  // Let every queued poll finish and the pipeline empty; check on the rising
  // edge, where the queue and in_tvalid are settled
  task automatic wait_idle();
    while (pending_polls.size() != 0 || in_tvalid || predicted_results.size() != 0)
      @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Write all three registers; junk above the id byte must be ignored
  task automatic configure(input logic [31:0] active_ms, input logic [31:0] pause_ms,
                           input logic [7:0] id);
    logic [31:0] id_word;
    id_word       = $urandom;
    id_word[7:0]  = id;
    write_reg(CFG_ACTIVE_BUDGET, active_ms);
    write_reg(CFG_PAUSE_BUDGET, pause_ms);
    write_reg(CFG_TASK_ID, id_word);
  endtask

  function automatic logic [31:0] pick_budget();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return $urandom;
      default: return $urandom_range(0, 400);
    endcase
  endfunction

  initial begin
    logic [7:0] id;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // Reset defaults: no task id, so init holds even with go written
    poll(0, 1'b0, 1'b0);
    tick_ms = '1;
    poll(0, 1'b1, 1'b1);
    poll(5, 1'b0, 1'b0);
    wait_idle();

    // Zero budgets and a negative id other than none
    configure('0, '0, 8'h80);
    poll(3, 1'b0, 1'b0);  // leave init
    poll(1, 1'b1, 1'b1);  // go written on ready entry is lost
    poll(1, 1'b0, 1'b0);
    poll(2, 1'b1, 1'b1);  // start active
    poll(4, 1'b0, 1'b0);  // entry sets the mark
    poll(10, 1'b0, 1'b0); // minimum tick reached, budget spent
    poll(0, 1'b0, 1'b0);
    poll(9, 1'b0, 1'b0);  // just under the minimum tick
    poll(1, 1'b0, 1'b0);  // pause done
    poll(1, 1'b0, 1'b0);  // announce
    wait_idle();

    // Go dropped with budget spent, then tick wrap with full pause budget
    configure(32'd25, '1, 8'hFE);
    poll(1, 1'b1, 1'b1);
    poll(0, 1'b0, 1'b0);
    poll(10, 1'b1, 1'b0); // pause wins over go low
    poll(0, 1'b0, 1'b0);
    poll(10, 1'b0, 1'b0);
    poll(1, 1'b0, 1'b0);  // reload 25 / max
    tick_ms = 32'hFFFF_FFF8;
    poll(0, 1'b1, 1'b1);
    poll(2, 1'b0, 1'b0);
    poll(12, 1'b1, 1'b0); // elapsed across the wrap
    poll(1, 1'b0, 1'b0);
    wait_idle();

    // Random phases: small budgets mostly, with rare huge time jumps
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      idle_on = (ph % 3 != 2) && (ph < RANDOM_PHASES - 2);
      case ($urandom_range(0, 9))
        0:       id = TASK_ID_NONE;
        1:       id = 8'($urandom_range(128, 254));
        default: id = 8'($urandom_range(0, 127));
      endcase
      if (ph == 0) configure('1, '0, 8'd127);
      else if (ph == 1) configure('0, '1, 8'd0);
      else configure(pick_budget(), pick_budget(), id);
      repeat (POLLS_PER_PHASE) begin
        logic [31:0] step_ms;
        case ($urandom_range(0, 19))
          0:       step_ms = '0;
          1:       step_ms = $urandom;
          2, 3:    step_ms = $urandom_range(10, 80);
          default: step_ms = $urandom_range(0, 14);
        endcase
        poll(step_ms, $urandom_range(0, 4) == 0, $urandom_range(0, 3) != 0);
      end
      wait_idle();
    end

    repeat (8) @(negedge clk);
    if (predicted_results.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", predicted_results.size()));
    if (mismatch_count == 0) begin
      $display("active_pause_duty_sequencer regression: pass");
    end else begin
      $display("active_pause_duty_sequencer regression: fail");
    end
    $finish;
  end

endmodule
